[design/slot_table_with_id_allocation_unit_defines.svh]
// Assertion macros used by the slot table design file.
`ifndef SLOT_TABLE_WITH_ID_ALLOCATION_UNIT_DEFINES_SVH
`define SLOT_TABLE_WITH_ID_ALLOCATION_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define STIDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define STIDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/stida_pkg.sv]
package stida_pkg;

   // Table size default.
   localparam int SLOTS_DEF = 8;

   // Field widths.
   localparam int OP_W       = 2;
   localparam int KEY_W      = 8;
   localparam int DAYS_W     = 7;
   localparam int HOUR_W     = 5;
   localparam int MINUTE_W   = 6;
   localparam int STRATEGY_W = 3;
   localparam int STATUS_W   = 2;
   localparam int USED_W     = 4;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

   // Key values with a special meaning.
   localparam logic [KEY_W-1:0] KEY_EMPTY = 8'd0;
   localparam logic [KEY_W-1:0] KEY_MAX   = 8'd255;

   // Stored payload of one slot, 23 bits, enabled in bit 0.
   typedef struct packed {
      logic [STRATEGY_W-1:0] strategy;
      logic                  action;
      logic [MINUTE_W-1:0]   minute;
      logic [HOUR_W-1:0]     hour;
      logic [DAYS_W-1:0]     days;
      logic                  enabled;
   } payload_type;

endpackage

[design/slot_table_with_id_allocation_unit.sv]
// Channel   | Direction | Handshake              | Contents
// ----------+-----------+------------------------+---------------------------------------
// req_      | in        | req_valid / req_stall  | opcode, entry key, entry payload
// rsp_      | out       | rsp_valid / rsp_stall  | status, key, found payload, used slots
//
// Scan: every request walks the whole table once through the single slot read port,
//    and a new request is taken only after the previous one has been committed.
// Reset: synchronous and active high; the per-slot valid bits empty every slot at once.
// Stalls: a finished result waits in the output register; the next request is
//    already accepted and scanned meanwhile, and only its commit waits for rsp_stall.

module slot_table_with_id_allocation_unit #(
   parameter int SLOTS = stida_pkg::SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [stida_pkg::OP_W-1:0]        req_opcode,
   input  logic [stida_pkg::KEY_W-1:0]       req_entry_key,
   input  logic                              req_entry_enabled,
   input  logic [stida_pkg::DAYS_W-1:0]      req_entry_days,
   input  logic [stida_pkg::HOUR_W-1:0]      req_entry_hour,
   input  logic [stida_pkg::MINUTE_W-1:0]    req_entry_minute,
   input  logic                              req_entry_action,
   input  logic [stida_pkg::STRATEGY_W-1:0]  req_entry_strategy,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [stida_pkg::STATUS_W-1:0]    rsp_status,
   output logic [stida_pkg::KEY_W-1:0]       rsp_result_key,
   output logic                              rsp_found_enabled,
   output logic [stida_pkg::DAYS_W-1:0]      rsp_found_days,
   output logic [stida_pkg::HOUR_W-1:0]      rsp_found_hour,
   output logic [stida_pkg::MINUTE_W-1:0]    rsp_found_minute,
   output logic                              rsp_found_action,
   output logic [stida_pkg::STRATEGY_W-1:0]  rsp_found_strategy,
   output logic [stida_pkg::USED_W-1:0]      rsp_used_slots
);
   import stida_pkg::*;

`include "slot_table_with_id_allocation_unit_defines.svh"

   // Slot index, scan counter (reaches SLOTS) and occupancy count widths.
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SC_W  = $clog2(SLOTS + 1);
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   // Sequencer and request registers.
   logic [1:0]       state_ff, state_in;
   logic [SC_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   payload_type      pay_ff, pay_in;

   // One-slot read stage of the shared scan unit.
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff;
   logic [KEY_W-1:0] rd_key_ff;
   logic             rd_kv_ff;
   payload_type      rd_pay_ff;
   logic [KEY_W-1:0] key_eff;

   // Scan accumulators.
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             match_found_ff, match_found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   payload_type      match_pay_ff, match_pay_in;
   logic [KEY_W-1:0] max_key_ff, max_key_in;

   // Table storage: keys and payloads in memories, emptiness in valid flops.
   logic [KEY_W-1:0] key_mem_ff [SLOTS];
   payload_type      pay_mem_ff [SLOTS];
   logic [SLOTS-1:0] slot_vld_ff, slot_vld_in;
   logic [CNT_W-1:0] occ_cnt_ff, occ_cnt_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   payload_type         rsp_pay_ff, rsp_pay_in;
   logic [USED_W-1:0]   rsp_used_ff, rsp_used_in;

   // Commit decisions.
   logic              req_take;
   logic              issue;
   logic [IDX_W-1:0]  rd_addr;
   logic              commit_go;
   logic              insert_ok;
   logic              remove_ok;
   logic              lookup_ok;
   logic [KEY_W-1:0]  new_key;
   logic [CNT_W+USED_W-1:0] cnt_ext;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // A read is issued for each slot in turn while the counter is below SLOTS.
   assign issue   = (state_ff == S_SCAN) && (scan_cnt_ff < SC_W'(SLOTS));
   assign rd_addr = scan_cnt_ff[IDX_W-1:0];

   // An empty slot reads as key zero whatever the key memory holds.
   assign key_eff = rd_kv_ff ? rd_key_ff : KEY_EMPTY;

   // The result may be committed once the output register is free or draining.
   assign commit_go = (state_ff == S_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   assign insert_ok = (op_ff == OP_INSERT) && free_found_ff && (max_key_ff != KEY_MAX);
   assign remove_ok = (op_ff == OP_REMOVE) && match_found_ff;
   assign lookup_ok = (op_ff == OP_LOOKUP) && match_found_ff;
   assign new_key   = max_key_ff + KEY_W'(1);

   always_comb begin
      state_in       = state_ff;
      scan_cnt_in    = scan_cnt_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      pay_in         = pay_ff;
      chk_vld_in     = issue;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_pay_in   = match_pay_ff;
      max_key_in     = max_key_ff;
      slot_vld_in    = slot_vld_ff;
      occ_cnt_in     = occ_cnt_ff;
      cnt_ext        = '0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_pay_in     = rsp_pay_ff;
      rsp_used_in    = rsp_used_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in            = req_opcode;
               key_in           = req_entry_key;
               pay_in.enabled   = req_entry_enabled;
               pay_in.days      = req_entry_days;
               pay_in.hour      = req_entry_hour;
               pay_in.minute    = req_entry_minute;
               pay_in.action    = req_entry_action;
               pay_in.strategy  = req_entry_strategy;
               // The entry's own key takes part in the largest-key search.
               max_key_in       = req_entry_key;
               free_found_in    = 1'b0;
               match_found_in   = 1'b0;
               scan_cnt_in      = '0;
               state_in         = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + SC_W'(1);
            end else begin
               // The last slot is in the check stage now and is folded in below.
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (commit_go) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = KEY_EMPTY;
               rsp_pay_in    = '0;
               rsp_status_in = ST_MISSING;
               case (op_ff)
                  OP_INSERT: begin
                     rsp_status_in = insert_ok ? ST_OK : ST_FULL;
                     if (insert_ok) begin
                        rsp_key_in               = new_key;
                        slot_vld_in[free_idx_ff] = 1'b1;
                        occ_cnt_in               = occ_cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (remove_ok) begin
                        rsp_status_in             = ST_OK;
                        rsp_key_in                = key_ff;
                        slot_vld_in[match_idx_ff] = 1'b0;
                        occ_cnt_in                = occ_cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_LOOKUP: begin
                     if (lookup_ok) begin
                        rsp_status_in = ST_OK;
                        rsp_key_in    = key_ff;
                        rsp_pay_in    = match_pay_ff;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_MISSING;
                  end
               endcase
               cnt_ext     = {{USED_W{1'b0}}, occ_cnt_in};
               rsp_used_in = cnt_ext[USED_W-1:0];
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Fold the slot in the check stage into the scan accumulators.
      if (chk_vld_ff) begin
         if ((key_eff == KEY_EMPTY) && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
         if (key_eff > max_key_ff) begin
            max_key_in = key_eff;
         end
         // Key zero never matches: empty slots also read as zero.
         if ((key_ff != KEY_EMPTY) && (key_eff == key_ff) && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = chk_idx_ff;
            match_pay_in   = rd_pay_ff;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         slot_vld_ff  <= '0;
         occ_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         slot_vld_ff  <= slot_vld_in;
         occ_cnt_ff   <= occ_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      scan_cnt_ff    <= scan_cnt_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      pay_ff         <= pay_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_pay_ff   <= match_pay_in;
      max_key_ff     <= max_key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_pay_ff     <= rsp_pay_in;
      rsp_used_ff    <= rsp_used_in;
   end

   // Slot memories: one read port used by the scan, one write port used at commit.
   always_ff @(posedge clock) begin
      if (commit_go && insert_ok) begin
         key_mem_ff[free_idx_ff] <= new_key;
         pay_mem_ff[free_idx_ff] <= pay_ff;
      end
      if (issue) begin
         rd_key_ff  <= key_mem_ff[rd_addr];
         rd_pay_ff  <= pay_mem_ff[rd_addr];
         rd_kv_ff   <= slot_vld_ff[rd_addr];
         chk_idx_ff <= rd_addr;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_key     = rsp_key_ff;
   assign rsp_found_enabled  = rsp_pay_ff.enabled;
   assign rsp_found_days     = rsp_pay_ff.days;
   assign rsp_found_hour     = rsp_pay_ff.hour;
   assign rsp_found_minute   = rsp_pay_ff.minute;
   assign rsp_found_action   = rsp_pay_ff.action;
   assign rsp_found_strategy = rsp_pay_ff.strategy;
   assign rsp_used_slots     = rsp_used_ff;

   // The occupancy count always agrees with the number of valid slots.
   `STIDA_ASSERT_NOW(a_count_matches_valid, clock, reset, 1'b1, occ_cnt_ff == $countones(slot_vld_ff), "occupancy count disagrees with valid slots")
   // A slot chosen for insertion must be empty.
   `STIDA_ASSERT_NOW(a_free_slot_empty, clock, reset, (state_ff == S_COMMIT) && free_found_ff, !slot_vld_ff[free_idx_ff], "free slot is already occupied")
   // A matched slot must be occupied.
   `STIDA_ASSERT_NOW(a_match_slot_full, clock, reset, (state_ff == S_COMMIT) && match_found_ff, slot_vld_ff[match_idx_ff], "matched slot is empty")
   // A successful insert raises the count by one.
   `STIDA_ASSERT_NEXT(a_insert_counts, clock, reset, commit_go && insert_ok, occ_cnt_ff == $past(occ_cnt_ff) + CNT_W'(1), "insert did not raise the count")

endmodule
